// ===== rtl/pan_tilt_command_frame_encoder_assert.svh =====
// assertion macros for the pan/tilt frame encoder
// used by the top level only, no other dependencies
`ifndef PAN_TILT_COMMAND_FRAME_ENCODER_ASSERT_SVH
`define PAN_TILT_COMMAND_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication
`define PTCFE_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptcfe check failed");

// next-cycle implication
`define PTCFE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptcfe check failed");

`endif

// ===== rtl/ptcfe_pkg.sv =====
// types, constants and microcode program of the pan/tilt frame encoder
// no dependencies
package ptcfe_pkg;

  typedef enum logic [2:0] {
    REQ_PAN   = 3'd0,
    REQ_TILT  = 3'd1,
    REQ_SPEED = 3'd2,
    REQ_JOG   = 3'd3,
    REQ_STOP  = 3'd4
  } req_kind_e;

  typedef enum logic [0:0] {
    CFG_LINK_MODE = 1'b0,
    CFG_NORTH_OFS = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_ADD,
    OP_WRAP_HI,
    OP_WRAP_LO,
    OP_WORDS,
    OP_SUM,
    OP_EMIT
  } uop_e;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_ACCEPT,
    COND_EMIT_DONE
  } cond_e;

  localparam int unsigned StepW    = 3;
  localparam int unsigned FrameLen = 9;
  localparam int unsigned PosW     = 4;

  typedef logic [StepW-1:0] step_t;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    step_t next;
  } ucw_t;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] ADDR_BYTE = 8'h01;
  localparam logic [7:0] CMD_POS   = 8'h06;
  localparam logic [7:0] CMD_NONE  = 8'h00;
  localparam logic [7:0] KEY_NONE  = 8'h00;
  localparam logic [7:0] KEY_SPEED = 8'hA0;
  localparam logic [7:0] KEY_STOP  = 8'hA1;
  localparam logic [15:0] WORD_BIAS = 16'h8000;

  localparam logic signed [17:0] WRAP_LIM  = 18'sd18000;
  localparam logic signed [17:0] WRAP_SPAN = 18'sd36000;

  localparam logic [PosW-1:0] LAST_POS = PosW'(FrameLen - 1);

  // microcode: one control word per step
  function automatic ucw_t ucode(input step_t s);
    ucw_t w;
    unique case (s)
      3'd0:    w = '{op: OP_WAIT,    cond: COND_ACCEPT,    next: 3'd1};
      3'd1:    w = '{op: OP_ADD,     cond: COND_ALWAYS,    next: 3'd2};
      3'd2:    w = '{op: OP_WRAP_HI, cond: COND_ALWAYS,    next: 3'd3};
      3'd3:    w = '{op: OP_WRAP_LO, cond: COND_ALWAYS,    next: 3'd4};
      3'd4:    w = '{op: OP_WORDS,   cond: COND_ALWAYS,    next: 3'd5};
      3'd5:    w = '{op: OP_SUM,     cond: COND_ALWAYS,    next: 3'd6};
      3'd6:    w = '{op: OP_EMIT,    cond: COND_EMIT_DONE, next: 3'd0};
      default: w = '{op: OP_WAIT,    cond: COND_ALWAYS,    next: 3'd0};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/ptcfe_req_if.sv =====
// request channel of the pan/tilt frame encoder
// depends on nothing
interface ptcfe_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [16:0] angle_centideg;
  logic signed [12:0] pan_rate;
  logic signed [12:0] tilt_rate;

  modport source (output valid, req_type, angle_centideg, pan_rate, tilt_rate,
                  input ready);
  modport sink   (input valid, req_type, angle_centideg, pan_rate, tilt_rate,
                  output ready);
endinterface

// ===== rtl/ptcfe_byte_if.sv =====
// output byte channel of the pan/tilt frame encoder
// depends on nothing
interface ptcfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, out_byte, frame_end, input ready);
  modport sink   (input valid, out_byte, frame_end, output ready);
endinterface

// ===== rtl/pan_tilt_command_frame_encoder.sv =====
// pan/tilt rotator command frame encoder, top level
// depends on ptcfe_pkg, ptcfe_req_if, ptcfe_byte_if and the assertion header
`include "pan_tilt_command_frame_encoder_assert.svh"

// Each request word builds one 9-byte command frame (sync, address, command,
// key, two 16-bit words high byte first, checksum) and sends it one byte per
// word on frame_o, frame_end marking the last byte. With link_mode at 0 every
// 0xFF byte goes out twice, so a frame is 9 bytes plus one per 0xFF byte in
// it. A microcode sequencer runs the work: the accept step, five build steps
// (offset add, two wrap steps, word build, checksum), then the emit step, which
// repeats for each output byte. The next request is taken right after the last
// byte enters the output register. Request kinds 5 to 7 are taken and dropped
// without building a frame.
// Configuration writes are meant for idle periods only.
module pan_tilt_command_frame_encoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  ptcfe_req_if.sink         req_i,
  ptcfe_byte_if.source      frame_o
);

  ptcfe_pkg::step_t step_q, step_d;
  ptcfe_pkg::ucw_t  ucw;

  logic               link_mode_q;
  logic signed [15:0] north_ofs_q;

  logic [2:0]         kind_q;
  logic signed [16:0] angle_q;
  logic signed [12:0] pspd_q;
  logic signed [12:0] tspd_q;
  logic signed [17:0] val_q;
  logic [7:0]         frame_q [ptcfe_pkg::FrameLen];

  logic [ptcfe_pkg::PosW-1:0] pos_q;
  logic                       stuff_q;
  logic                       out_valid_q;
  logic [7:0]                 out_byte_q;
  logic                       out_end_q;

  logic        req_fire;
  logic        kind_ok;
  logic        slot_free;
  logic        emit_fire;
  logic        emit_adv;
  logic        emit_last;
  logic        emit_stuff;
  logic [7:0]  emit_byte;
  logic        cond_ok;
  logic        is_pan;

  logic [15:0] pos_word;
  logic [14:0] pspd_x;
  logic [14:0] tspd_x;
  logic [15:0] sw1;
  logic [15:0] sw2;
  logic [7:0]  cmd_b;
  logic [7:0]  key_b;
  logic [15:0] w1;
  logic [15:0] w2;
  logic [7:0]  csum;

  assign ucw       = ptcfe_pkg::ucode(step_q);
  assign req_i.ready = (ucw.op == ptcfe_pkg::OP_WAIT);
  assign req_fire  = req_i.valid && req_i.ready;
  assign kind_ok   = (req_i.req_type <= 3'(ptcfe_pkg::REQ_STOP));
  assign is_pan    = (kind_q == 3'(ptcfe_pkg::REQ_PAN));

  assign slot_free = !out_valid_q || frame_o.ready;
  assign emit_fire = (ucw.op == ptcfe_pkg::OP_EMIT) && slot_free;
  assign emit_byte = frame_q[pos_q];
  assign emit_last = (pos_q == ptcfe_pkg::LAST_POS);
  // first copy of a doubled 0xff holds the position
  assign emit_stuff = !stuff_q && !link_mode_q && (emit_byte == ptcfe_pkg::SYNC_BYTE);
  assign emit_adv  = !emit_stuff;

  always_comb begin
    unique case (ucw.cond)
      ptcfe_pkg::COND_ALWAYS:    cond_ok = 1'b1;
      ptcfe_pkg::COND_ACCEPT:    cond_ok = req_fire && kind_ok;
      ptcfe_pkg::COND_EMIT_DONE: cond_ok = emit_fire && emit_adv && emit_last;
      default:                   cond_ok = 1'b0;
    endcase
    step_d = cond_ok ? ucw.next : step_q;
  end

  // word build: floor(v/2) is the arithmetic shift, bias flips the top bit
  assign pos_word = {~val_q[16], val_q[15:1]};
  assign pspd_x   = {{2{pspd_q[12]}}, pspd_q};
  assign tspd_x   = {{2{tspd_q[12]}}, tspd_q};
  assign sw1 = {pspd_x[12:0], 3'b000} + {pspd_x[14:0], 1'b0} + ptcfe_pkg::WORD_BIAS;
  assign sw2 = {tspd_x[12:0], 3'b000} + {tspd_x[14:0], 1'b0} + ptcfe_pkg::WORD_BIAS;

  always_comb begin
    cmd_b = ptcfe_pkg::CMD_NONE;
    key_b = ptcfe_pkg::KEY_NONE;
    w1    = '0;
    w2    = '0;
    unique case (kind_q)
      3'(ptcfe_pkg::REQ_PAN): begin
        cmd_b = ptcfe_pkg::CMD_POS;
        w1    = pos_word;
      end
      3'(ptcfe_pkg::REQ_TILT): begin
        cmd_b = ptcfe_pkg::CMD_POS;
        w2    = pos_word;
      end
      3'(ptcfe_pkg::REQ_SPEED): begin
        key_b = ptcfe_pkg::KEY_SPEED;
        w1    = sw1;
        w2    = sw2;
      end
      3'(ptcfe_pkg::REQ_JOG): begin
        w1 = sw1;
        w2 = sw2;
      end
      3'(ptcfe_pkg::REQ_STOP): begin
        key_b = ptcfe_pkg::KEY_STOP;
      end
      default: begin
        cmd_b = ptcfe_pkg::CMD_NONE;
      end
    endcase
  end

  assign csum = frame_q[1] + frame_q[2] + frame_q[3] + frame_q[4]
              + frame_q[5] + frame_q[6] + frame_q[7];

  // control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      link_mode_q <= 1'b0;
      north_ofs_q <= '0;
      pos_q       <= '0;
      stuff_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ptcfe_pkg::CFG_LINK_MODE: link_mode_q <= cfg_wdata_i[0];
          ptcfe_pkg::CFG_NORTH_OFS: north_ofs_q <= cfg_wdata_i;
          default:                  link_mode_q <= link_mode_q;
        endcase
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
        stuff_q     <= emit_stuff;
        if (emit_adv) begin
          pos_q <= emit_last ? '0 : pos_q + 1'b1;
        end
      end else if (frame_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_byte_q <= emit_byte;
      out_end_q  <= emit_adv && emit_last;
    end
    unique case (ucw.op)
      ptcfe_pkg::OP_WAIT: begin
        if (req_fire) begin
          kind_q  <= req_i.req_type;
          angle_q <= req_i.angle_centideg;
          pspd_q  <= req_i.pan_rate;
          tspd_q  <= req_i.tilt_rate;
        end
      end
      ptcfe_pkg::OP_ADD: begin
        val_q <= is_pan ? ({angle_q[16], angle_q} + {{2{north_ofs_q[15]}}, north_ofs_q})
                        : {angle_q[16], angle_q};
      end
      ptcfe_pkg::OP_WRAP_HI: begin
        if (is_pan && (val_q > ptcfe_pkg::WRAP_LIM)) val_q <= val_q - ptcfe_pkg::WRAP_SPAN;
      end
      ptcfe_pkg::OP_WRAP_LO: begin
        if (is_pan && (val_q < -ptcfe_pkg::WRAP_LIM)) val_q <= val_q + ptcfe_pkg::WRAP_SPAN;
      end
      ptcfe_pkg::OP_WORDS: begin
        frame_q[0] <= ptcfe_pkg::SYNC_BYTE;
        frame_q[1] <= ptcfe_pkg::ADDR_BYTE;
        frame_q[2] <= cmd_b;
        frame_q[3] <= key_b;
        frame_q[4] <= w1[15:8];
        frame_q[5] <= w1[7:0];
        frame_q[6] <= w2[15:8];
        frame_q[7] <= w2[7:0];
      end
      ptcfe_pkg::OP_SUM: begin
        frame_q[8] <= csum;
      end
      default: begin
        val_q <= val_q;
      end
    endcase
  end

  assign frame_o.valid     = out_valid_q;
  assign frame_o.out_byte  = out_byte_q;
  assign frame_o.frame_end = out_end_q;

  `PTCFE_ASSERT_NXT(a_accept_starts_build, clk_i, rst_ni,
                    req_fire && kind_ok, ucw.op == ptcfe_pkg::OP_ADD)
  `PTCFE_ASSERT_NOW(a_stuff_holds_ff, clk_i, rst_ni,
                    stuff_q, out_valid_q && (out_byte_q == ptcfe_pkg::SYNC_BYTE))
  `PTCFE_ASSERT_NOW(a_end_rewinds, clk_i, rst_ni,
                    out_valid_q && out_end_q, (pos_q == '0) && !stuff_q)

endmodule
